>>> rtl/jittered_line_dab_stepper_top_assert.svh
// ----------------------------------------------------------------------------
// jittered_line_dab_stepper_top_assert.svh
// Assertion macros used by the dab stepper RTL. They expect clk and arst_n
// in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef JITTERED_LINE_DAB_STEPPER_TOP_ASSERT_SVH
`define JITTERED_LINE_DAB_STEPPER_TOP_ASSERT_SVH

// same-cycle implication
`define JLDS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JLDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jlds_pkg.sv
// ----------------------------------------------------------------------------
// jlds_pkg
// Types, constants and the jitter quotient function of the dab stepper.
// ----------------------------------------------------------------------------
package jlds_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int KIND_BITS      = 2;
	localparam int SPAN_BITS      = 16;
	localparam int RAND_BITS      = 15;
	localparam int RAND_SHIFT     = 16;
	localparam int SEED_BITS      = 32;
	localparam int PROD_BITS      = RAND_BITS + SPAN_BITS;
	localparam int FRAC_BITS      = 8;
	localparam int QUOT_BITS      = PROD_BITS - FRAC_BITS - RAND_BITS;
	localparam int REM_BITS       = RAND_BITS + 1;

	localparam logic [SEED_BITS-1:0] LCG_MUL = 32'd214013;
	localparam logic [SEED_BITS-1:0] LCG_ADD = 32'd2531011;

	// two draws folded into one step
	localparam logic [63:0] LCG_MUL2_W = 64'(LCG_MUL) * 64'(LCG_MUL);
	localparam logic [63:0] LCG_ADD2_W = 64'(LCG_ADD) * (64'(LCG_MUL) + 64'd1);
	localparam logic [SEED_BITS-1:0] LCG_MUL2 = LCG_MUL2_W[SEED_BITS-1:0];
	localparam logic [SEED_BITS-1:0] LCG_ADD2 = LCG_ADD2_W[SEED_BITS-1:0];

	localparam logic [RAND_BITS-1:0] RAND_TOP = 15'h7FFF;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_START   = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_RESEED  = 2'd2
	} kind_t;

	typedef struct packed {
		logic start;
		logic advance;
		logic reseed;
	} cmd_t;

	typedef struct packed {
		logic dab_valid;
		logic done;
	} step_ctl_t;

	// floor(prod / (32767 * 256)); estimate by 2^15, then one correction
	function automatic logic [QUOT_BITS-1:0] jitter_quot(input logic [PROD_BITS-1:0] prod);
		logic [PROD_BITS-FRAC_BITS-1:0] t;
		logic [QUOT_BITS-1:0]           q0;
		logic [REM_BITS-1:0]            rem;
		t   = prod[PROD_BITS-1:FRAC_BITS];
		q0  = t[PROD_BITS-FRAC_BITS-1:RAND_BITS];
		rem = {1'b0, t[RAND_BITS-1:0]} + REM_BITS'(q0);
		return (rem >= {1'b0, RAND_TOP}) ? q0 + QUOT_BITS'(1) : q0;
	endfunction

endpackage

>>> rtl/jlds_item_if.sv
// ----------------------------------------------------------------------------
// jlds_item_if
// Request channel of the dab stepper: kind and segment endpoints.
// ----------------------------------------------------------------------------
interface jlds_item_if #(
	parameter int COORD_BITS = jlds_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [jlds_pkg::KIND_BITS-1:0]    kind;
	logic signed [COORD_BITS-1:0]      start_x;
	logic signed [COORD_BITS-1:0]      start_y;
	logic signed [COORD_BITS-1:0]      end_x;
	logic signed [COORD_BITS-1:0]      end_y;

	modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> rtl/jlds_dab_if.sv
// ----------------------------------------------------------------------------
// jlds_dab_if
// Result channel of the dab stepper: dab position or end of segment.
// ----------------------------------------------------------------------------
interface jlds_dab_if #(
	parameter int COORD_BITS = jlds_pkg::COORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        dab_valid;
	logic signed [COORD_BITS:0]  dab_x;
	logic signed [COORD_BITS:0]  dab_y;
	logic                        done_res;

	modport source (output valid, dab_valid, dab_x, dab_y, done_res, input ready);
	modport sink   (input valid, dab_valid, dab_x, dab_y, done_res, output ready);
endinterface

>>> rtl/jlds_cfg_if.sv
// ----------------------------------------------------------------------------
// jlds_cfg_if
// Configuration write channel: jitter span.
// ----------------------------------------------------------------------------
interface jlds_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [jlds_pkg::SPAN_BITS-1:0]   jitter_span;

	modport source (output valid, jitter_span, input ready);
	modport sink   (input valid, jitter_span, output ready);
endinterface

>>> rtl/jlds_lcg.sv
// ----------------------------------------------------------------------------
// jlds_lcg
// 32-bit LCG; yields both draws of an advance request in the same cycle.
// ----------------------------------------------------------------------------
module jlds_lcg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  jlds_pkg::cmd_t                    cmd,
	output logic [jlds_pkg::RAND_BITS-1:0]    rand_x,
	output logic [jlds_pkg::RAND_BITS-1:0]    rand_y
);
	logic [jlds_pkg::SEED_BITS-1:0] seed_q;
	logic [jlds_pkg::SEED_BITS-1:0] seed_x;
	logic [jlds_pkg::SEED_BITS-1:0] seed_y;

	assign seed_x = seed_q * jlds_pkg::LCG_MUL  + jlds_pkg::LCG_ADD;
	assign seed_y = seed_q * jlds_pkg::LCG_MUL2 + jlds_pkg::LCG_ADD2;

	assign rand_x = seed_x[jlds_pkg::RAND_SHIFT+jlds_pkg::RAND_BITS-1:jlds_pkg::RAND_SHIFT];
	assign rand_y = seed_y[jlds_pkg::RAND_SHIFT+jlds_pkg::RAND_BITS-1:jlds_pkg::RAND_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cmd.reseed) begin
			seed_q <= '0;
		end else if (cmd.advance) begin
			seed_q <= seed_y;
		end
	end
endmodule

>>> rtl/jlds_stepper.sv
// ----------------------------------------------------------------------------
// jlds_stepper
// Bresenham segment state; one step per advance request.
// ----------------------------------------------------------------------------
module jlds_stepper #(
	parameter int COORD_BITS = jlds_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jlds_pkg::cmd_t                cmd,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	output jlds_pkg::step_ctl_t           ctl,
	output logic signed [COORD_BITS-1:0]  pos_x,
	output logic signed [COORD_BITS-1:0]  pos_y
);
	localparam int ERR_BITS = COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q;
	logic [COORD_BITS-1:0]        span_dx_q, span_dy_q;
	logic                         step_x_neg_q, step_y_neg_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic                         active_q;

	logic signed [COORD_BITS:0]   diff_x, diff_y;
	logic [COORD_BITS-1:0]        abs_dx, abs_dy;
	logic signed [ERR_BITS-1:0]   err_init;

	logic signed [ERR_BITS-1:0]   dx_e, dy_e, err_nxt;
	logic                         ending, move_x, move_y;

	// segment load
	assign diff_x = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
	assign diff_y = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
	assign abs_dx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
	assign abs_dy = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
	assign err_init = (abs_dx > abs_dy) ? $signed({3'b000, abs_dx[COORD_BITS-1:1]})
		: -$signed({3'b000, abs_dy[COORD_BITS-1:1]});

	// one step
	assign dx_e    = $signed({2'b00, span_dx_q});
	assign dy_e    = $signed({2'b00, span_dy_q});
	assign ending  = !active_q || (pos_x_q == goal_x_q && pos_y_q == goal_y_q);
	assign move_x  = err_q > -dx_e;
	assign move_y  = err_q < dy_e;
	assign err_nxt = err_q - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);

	always_comb begin
		pos_x = pos_x_q;
		pos_y = pos_y_q;
		if (move_x) begin
			pos_x = step_x_neg_q ? pos_x_q - COORD_BITS'(1) : pos_x_q + COORD_BITS'(1);
		end
		if (move_y) begin
			pos_y = step_y_neg_q ? pos_y_q - COORD_BITS'(1) : pos_y_q + COORD_BITS'(1);
		end
	end

	assign ctl.dab_valid = !ending;
	assign ctl.done      = ending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			span_dx_q    <= '0;
			span_dy_q    <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q        <= '0;
			active_q     <= 1'b0;
		end else if (cmd.start) begin
			pos_x_q      <= start_x;
			pos_y_q      <= start_y;
			goal_x_q     <= end_x;
			goal_y_q     <= end_y;
			span_dx_q    <= abs_dx;
			span_dy_q    <= abs_dy;
			step_x_neg_q <= start_x >= end_x;
			step_y_neg_q <= start_y >= end_y;
			err_q        <= err_init;
			active_q     <= 1'b1;
		end else if (cmd.advance) begin
			if (ending) begin
				active_q <= 1'b0;
			end else begin
				pos_x_q <= pos_x;
				pos_y_q <= pos_y;
				err_q   <= err_nxt;
			end
		end
	end
endmodule

>>> rtl/jlds_jitter.sv
// ----------------------------------------------------------------------------
// jlds_jitter
// Result pipeline: draw register, jitter multiply, scale and offset into the
// output register.
// ----------------------------------------------------------------------------
`include "jittered_line_dab_stepper_top_assert.svh"

module jlds_jitter #(
	parameter int COORD_BITS = jlds_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              ready,
	input  jlds_pkg::step_ctl_t               ctl,
	input  logic signed [COORD_BITS-1:0]      pos_x,
	input  logic signed [COORD_BITS-1:0]      pos_y,
	input  logic [jlds_pkg::RAND_BITS-1:0]    rand_x,
	input  logic [jlds_pkg::RAND_BITS-1:0]    rand_y,
	input  logic [jlds_pkg::SPAN_BITS-1:0]    jitter_span,
	jlds_dab_if.source                        dab
);
	logic                                 s1_v_q, s2_v_q, out_v_q;
	logic                                 ready1, ready2, ready_o;

	jlds_pkg::step_ctl_t                  ctl_s1, ctl_s2, ctl_q;
	logic signed [COORD_BITS-1:0]         pos_x_s1, pos_y_s1, pos_x_s2, pos_y_s2;
	logic [jlds_pkg::RAND_BITS-1:0]       rx_s1, ry_s1;
	logic [jlds_pkg::PROD_BITS-1:0]       prod_x_s2, prod_y_s2;
	logic [jlds_pkg::QUOT_BITS-1:0]       jit_x, jit_y;
	logic signed [COORD_BITS:0]           dab_x_d, dab_y_d, dab_x_q, dab_y_q;

	assign ready_o = !out_v_q || dab.ready;
	assign ready2  = !s2_v_q || ready_o;
	assign ready1  = !s1_v_q || ready2;
	assign ready   = ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ready1) begin
				s1_v_q <= push;
			end
			if (ready2) begin
				s2_v_q <= s1_v_q;
			end
			if (ready_o) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	assign jit_x = jlds_pkg::jitter_quot(prod_x_s2);
	assign jit_y = jlds_pkg::jitter_quot(prod_y_s2);
	assign dab_x_d = ctl_s2.dab_valid
		? {pos_x_s2[COORD_BITS-1], pos_x_s2} + (COORD_BITS+1)'(jit_x) : '0;
	assign dab_y_d = ctl_s2.dab_valid
		? {pos_y_s2[COORD_BITS-1], pos_y_s2} + (COORD_BITS+1)'(jit_y) : '0;

	always_ff @(posedge clk) begin
		if (ready1) begin
			ctl_s1   <= ctl;
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			rx_s1    <= rand_x;
			ry_s1    <= rand_y;
		end
		if (ready2) begin
			ctl_s2    <= ctl_s1;
			pos_x_s2  <= pos_x_s1;
			pos_y_s2  <= pos_y_s1;
			prod_x_s2 <= jlds_pkg::PROD_BITS'(rx_s1) * jlds_pkg::PROD_BITS'(jitter_span);
			prod_y_s2 <= jlds_pkg::PROD_BITS'(ry_s1) * jlds_pkg::PROD_BITS'(jitter_span);
		end
		if (ready_o) begin
			ctl_q   <= ctl_s2;
			dab_x_q <= dab_x_d;
			dab_y_q <= dab_y_d;
		end
	end

	assign dab.valid     = out_v_q;
	assign dab.dab_valid = ctl_q.dab_valid;
	assign dab.done_res  = ctl_q.done;
	assign dab.dab_x     = dab_x_q;
	assign dab.dab_y     = dab_y_q;

	`JLDS_ASSERT_SAME(a_one_flag, out_v_q, ctl_q.dab_valid != ctl_q.done, "result flags clash")
	`JLDS_ASSERT_SAME(a_done_zero, out_v_q && ctl_q.done, dab_x_q == '0 && dab_y_q == '0, "done result not zero")
	`JLDS_ASSERT_NEXT(a_s1_hold, s1_v_q && !ready2, s1_v_q, "stalled stage lost")
	`JLDS_ASSERT_NEXT(a_push_lands, push && ready1, s1_v_q, "pushed request lost")
endmodule

>>> rtl/jittered_line_dab_stepper_top.sv
// ----------------------------------------------------------------------------
// jittered_line_dab_stepper_top
// Bresenham line stepper emitting jittered dab positions. One request is
// taken every cycle unless result back-pressure stalls it. A start or
// reseed request updates state and gives no result; an advance request
// gives one result via LCG draw, jitter multiply and output registers;
// advances stream at one result per cycle while dab_out is ready. The
// jitter span register is written over the cfg channel, always ready.
// ----------------------------------------------------------------------------
module jittered_line_dab_stepper_top #(
	parameter int COORD_BITS = jlds_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	jlds_item_if.sink     item_in,
	jlds_dab_if.source    dab_out,
	jlds_cfg_if.sink      cfg
);
	logic [jlds_pkg::SPAN_BITS-1:0]   jitter_span_q;
	logic                             accept;
	logic                             pipe_ready;
	jlds_pkg::cmd_t                   cmd;
	jlds_pkg::step_ctl_t              step_ctl;
	logic signed [COORD_BITS-1:0]     step_x, step_y;
	logic [jlds_pkg::RAND_BITS-1:0]   rand_x, rand_y;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_span_q <= '0;
		end else if (cfg.valid) begin
			jitter_span_q <= cfg.jitter_span;
		end
	end

	assign item_in.ready = pipe_ready;
	assign accept        = item_in.valid && pipe_ready;

	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (item_in.kind)
				jlds_pkg::KIND_START:   cmd.start   = 1'b1;
				jlds_pkg::KIND_ADVANCE: cmd.advance = 1'b1;
				jlds_pkg::KIND_RESEED:  cmd.reseed  = 1'b1;
				default:                cmd         = '0;
			endcase
		end
	end

	jlds_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rand_x (rand_x),
		.rand_y (rand_y)
	);

	jlds_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.start_x (item_in.start_x),
		.start_y (item_in.start_y),
		.end_x   (item_in.end_x),
		.end_y   (item_in.end_y),
		.ctl     (step_ctl),
		.pos_x   (step_x),
		.pos_y   (step_y)
	);

	jlds_jitter #(
		.COORD_BITS (COORD_BITS)
	) u_jitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (cmd.advance),
		.ready       (pipe_ready),
		.ctl         (step_ctl),
		.pos_x       (step_x),
		.pos_y       (step_y),
		.rand_x      (rand_x),
		.rand_y      (rand_y),
		.jitter_span (jitter_span_q),
		.dab         (dab_out)
	);
endmodule

>>> tb/sv/jlds_dab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlds_dab_checker
// Watches the request, result and configuration channels of the dab stepper.
// It keeps its own copy of the line stepper, generator and jitter span, works
// out the dab each accepted advance request should give, and compares every
// accepted result field by field with the oldest outstanding dab.
// ----------------------------------------------------------------------------
module jlds_dab_checker (
	input  logic  clk,
	input  logic  arst_n,
	jlds_item_if  item_mon,
	jlds_dab_if   dab_mon,
	jlds_cfg_if   cfg_mon,
	output int    fail_count,
	output int    pending
);
	localparam longint unsigned JITTER_DIV = 64'd32767 * 64'd256;

	typedef struct packed {
		logic        dab_valid;
		logic [16:0] x;
		logic [16:0] y;
		logic        done;
	} dab_t;

	dab_t                           dabs_due[$];
	logic [jlds_pkg::SPAN_BITS-1:0] span_cfg;
	logic [jlds_pkg::SEED_BITS-1:0] seed;
	int                             pos_x, pos_y, goal_x, goal_y;
	int                             span_dx, span_dy, err;
	logic                           neg_x, neg_y, active;
	int                             fails = 0;

	task automatic flag_mismatch(string what, logic [16:0] got, logic [16:0] want);
		$display("%0t mismatch %s: got %0d, expected %0d", $time, what,
			$signed(got), $signed(want));
		fails++;
	endtask

	function automatic logic [jlds_pkg::RAND_BITS-1:0] draw_rand();
		seed = seed * jlds_pkg::LCG_MUL + jlds_pkg::LCG_ADD;
		return seed[30:16];
	endfunction

	function automatic int jitter_px(logic [jlds_pkg::RAND_BITS-1:0] r);
		return int'((64'(r) * 64'(span_cfg)) / JITTER_DIV);
	endfunction

	task automatic predict_dab(logic [jlds_pkg::KIND_BITS-1:0] kind, int sx, int sy,
		int ex, int ey);
		logic [jlds_pkg::RAND_BITS-1:0] rx, ry;
		int                             e2;
		dab_t                           d;
		case (kind)
		jlds_pkg::KIND_START: begin
			pos_x = sx;
			pos_y = sy;
			goal_x = ex;
			goal_y = ey;
			neg_x = !(sx < ex);
			neg_y = !(sy < ey);
			span_dx = (ex >= sx) ? ex - sx : sx - ex;
			span_dy = (ey >= sy) ? ey - sy : sy - ey;
			err = (span_dx > span_dy) ? span_dx / 2 : -(span_dy / 2);
			active = 1'b1;
		end
		jlds_pkg::KIND_RESEED: begin
			seed = '0;
		end
		jlds_pkg::KIND_ADVANCE: begin
			rx = draw_rand();
			ry = draw_rand();
			d = '0;
			if (!active || (pos_x == goal_x && pos_y == goal_y)) begin
				active = 1'b0;
				d.done = 1'b1;
			end else begin
				e2 = err;
				if (e2 > -span_dx) begin
					err -= span_dy;
					pos_x += neg_x ? -1 : 1;
				end
				if (e2 < span_dy) begin
					err += span_dx;
					pos_y += neg_y ? -1 : 1;
				end
				d.dab_valid = 1'b1;
				d.x = 17'(pos_x + jitter_px(rx));
				d.y = 17'(pos_y + jitter_px(ry));
			end
			dabs_due.push_back(d);
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		dab_t want;
		if (!arst_n) begin
			span_cfg = '0;
			seed = '0;
			pos_x = 0;
			pos_y = 0;
			goal_x = 0;
			goal_y = 0;
			span_dx = 0;
			span_dy = 0;
			err = 0;
			neg_x = 1'b0;
			neg_y = 1'b0;
			active = 1'b0;
			dabs_due.delete();
			fail_count <= fails;
			pending <= 0;
		end else begin
			if (dab_mon.valid && dab_mon.ready) begin
				if (dabs_due.size() == 0) begin
					flag_mismatch("unexpected result, dab_valid", 17'(dab_mon.dab_valid), 17'd0);
				end else begin
					want = dabs_due.pop_front();
					if (dab_mon.dab_valid !== want.dab_valid)
						flag_mismatch("dab_valid", 17'(dab_mon.dab_valid), 17'(want.dab_valid));
					if (dab_mon.dab_x !== want.x)
						flag_mismatch("dab_x", dab_mon.dab_x, want.x);
					if (dab_mon.dab_y !== want.y)
						flag_mismatch("dab_y", dab_mon.dab_y, want.y);
					if (dab_mon.done_res !== want.done)
						flag_mismatch("done_res", 17'(dab_mon.done_res), 17'(want.done));
				end
			end
			if (cfg_mon.valid && cfg_mon.ready)
				span_cfg = cfg_mon.jitter_span;
			if (item_mon.valid && item_mon.ready)
				predict_dab(item_mon.kind, item_mon.start_x, item_mon.start_y,
					item_mon.end_x, item_mon.end_y);
			fail_count <= fails;
			pending <= dabs_due.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the dab stepper testbench. Drives requests, jitter span writes and
// result back-pressure with random idle bursts; the checker beside the block
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	localparam logic [jlds_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_QUOTA = 140;

	logic clk;
	logic arst_n;
	int   cycles = 0;
	bit   quiet = 1'b0;
	int   fail_count;
	int   pending;

	jlds_item_if item_ch ();
	jlds_dab_if  dab_ch ();
	jlds_cfg_if  cfg_ch ();

	jittered_line_dab_stepper_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_ch),
		.dab_out (dab_ch),
		.cfg     (cfg_ch)
	);

	jlds_dab_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (item_ch),
		.dab_mon    (dab_ch),
		.cfg_mon    (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result back-pressure
	initial begin
		dab_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				dab_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				dab_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int clamp_coord(int v);
		return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
	endfunction

	function automatic int pick_base();
		case ($urandom_range(0, 5))
		0: return -32768 + int'($urandom_range(0, 6));
		1: return 32767 - int'($urandom_range(0, 6));
		default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic send_req(logic [jlds_pkg::KIND_BITS-1:0] k, int sx, int sy, int ex, int ey);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_ch.kind <= k;
		item_ch.start_x <= 16'(sx);
		item_ch.start_y <= 16'(sy);
		item_ch.end_x <= 16'(ex);
		item_ch.end_y <= 16'(ey);
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_span(logic [jlds_pkg::SPAN_BITS-1:0] v);
		drain_results();
		cfg_ch.jitter_span <= v;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(int quota);
		int sent, pick, steps, nadv, sx, sy, ex, ey;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				// short segment, walked to its end or dropped part way
				sx = pick_base();
				sy = pick_base();
				ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
				ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
				steps = (ex > sx) ? ex - sx : sx - ex;
				if (((ey > sy) ? ey - sy : sy - ey) > steps)
					steps = (ey > sy) ? ey - sy : sy - ey;
				if ($urandom_range(0, 7) == 0)
					nadv = $urandom_range(0, steps);
				else
					nadv = steps + $urandom_range(0, 2);
				send_req(jlds_pkg::KIND_START, sx, sy, ex, ey);
				sent++;
				repeat (nadv) begin
					send_req(jlds_pkg::KIND_ADVANCE, $urandom, $urandom, $urandom, $urandom);
					sent++;
				end
			end else if (pick < 86) begin
				send_req(jlds_pkg::KIND_ADVANCE, $urandom, $urandom, $urandom, $urandom);
				sent++;
			end else if (pick < 92) begin
				send_req(jlds_pkg::KIND_RESEED, $urandom, $urandom, $urandom, $urandom);
				sent++;
			end else if (pick < 95) begin
				send_req(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end else begin
				send_req(jlds_pkg::KIND_START, $urandom, $urandom, $urandom, $urandom);
				sent++;
				repeat ($urandom_range(1, 6)) begin
					send_req(jlds_pkg::KIND_ADVANCE, $urandom, $urandom, $urandom, $urandom);
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [jlds_pkg::SPAN_BITS-1:0] span;
		item_ch.valid <= 1'b0;
		item_ch.kind <= jlds_pkg::KIND_START;
		item_ch.start_x <= '0;
		item_ch.start_y <= '0;
		item_ch.end_x <= '0;
		item_ch.end_y <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.jitter_span <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance while idle, before any span write
		send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);
		write_span(16'hFFFF);
		// zero-length segment: done, then done again while idle
		send_req(jlds_pkg::KIND_START, 0, 0, 0, 0);
		send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);
		send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);
		// full-range diagonals both ways
		send_req(jlds_pkg::KIND_START, -32768, -32768, 32767, 32767);
		send_req(jlds_pkg::KIND_ADVANCE, -1, -1, -1, -1);
		send_req(jlds_pkg::KIND_ADVANCE, -1, -1, -1, -1);
		send_req(jlds_pkg::KIND_START, 32767, 32767, -32768, -32768);
		send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);
		send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);
		// shallow line at the top edge, run to its end
		send_req(jlds_pkg::KIND_START, 32767, 0, 32764, 1);
		repeat (4) send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);
		send_req(jlds_pkg::KIND_RESEED, 0, 0, 0, 0);
		send_req(KIND_UNUSED, -1, -1, -1, -1);
		// steep line after reseed
		send_req(jlds_pkg::KIND_START, 5, -3, 3, 4);
		repeat (3) send_req(jlds_pkg::KIND_ADVANCE, 0, 0, 0, 0);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
			0: span = 16'h0000;
			1: span = 16'($urandom_range(1, 16'hFFFE));
			2: span = 16'h0100;
			3: span = 16'($urandom);
			default: span = 16'hFFFF;
			endcase
			write_span(span);
			quiet = (phase == 4);
			run_phase(PHASE_QUOTA);
		end
		drain_results();

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/jlds_pkg.sv
rtl/jlds_item_if.sv
rtl/jlds_dab_if.sv
rtl/jlds_cfg_if.sv
rtl/jlds_lcg.sv
rtl/jlds_stepper.sv
rtl/jlds_jitter.sv
rtl/jittered_line_dab_stepper_top.sv
tb/sv/jlds_dab_checker.sv
tb/sv/tb.sv
